@@ src/xxh_pkg.sv @@
// Package with the xxHash64 primes and a helper function.
`default_nettype none
package xxh_pkg;
  localparam logic [63:0] PRIME1 = 64'd11400714785074694791;
  localparam logic [63:0] PRIME2 = 64'd14029467366897019727;
  localparam logic [63:0] PRIME3 = 64'd1609587929392839161;
  localparam logic [63:0] PRIME4 = 64'd9650029242287828579;
  localparam logic [63:0] PRIME5 = 64'd2870177450012600261;

  localparam int WORD_W  = 64;
  localparam int COUNT_W = 4;
  localparam int S_DATA_W = 72;

  localparam logic [COUNT_W-1:0] FULL_COUNT = 4'd8;

  function automatic logic [63:0] rotl64(input logic [63:0] x, input int r);
    rotl64 = (x << r) | (x >> (64 - r));
  endfunction
endpackage
`default_nettype wire

@@ src/xxh64_stream_hash_top.sv @@
// Streaming xxHash64 engine built around one shared 32x32 multiplier.
`default_nettype none
// Each input transfer is one little-endian 64-bit message word; tlast marks the final
// word, whose byte_count (0..8) gives its valid bytes. Every 64-bit multiply goes
// through a single 32x32 multiplier as three partial products (low*low, low*high,
// high*low). A plain word takes the transfer and one bookkeeping state, and a word
// that closes a 32-byte group adds 4 lanes x 2 multiplies. The last word then adds the
// lane merge when a group was seen, the length, each held word, a 4-byte piece, each
// single byte, the close of the tail and the avalanche with the output load.
// s_tready is high only while the sequencer is idle. The digest waits in an output
// register, so the next message may start while it is still unread; a second digest
// holds the sequencer until the first one is taken.
module xxh64_stream_hash_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [63:0] cfg_wdata,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [71:0] s_tdata,   // data_word [63:0], byte_count [67:64], zero pad
  input  wire logic        s_tlast,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [63:0]      m_tdata    // hash_value [63:0]
);
  localparam logic [4:0] ST_IDLE  = 5'd0;
  localparam logic [4:0] ST_RND_A = 5'd1;
  localparam logic [4:0] ST_RND_B = 5'd2;
  localparam logic [4:0] ST_POST  = 5'd3;
  localparam logic [4:0] ST_MRG_A = 5'd4;
  localparam logic [4:0] ST_MRG_B = 5'd5;
  localparam logic [4:0] ST_MRG_C = 5'd6;
  localparam logic [4:0] ST_ADDL  = 5'd7;
  localparam logic [4:0] ST_PW_A  = 5'd8;
  localparam logic [4:0] ST_PW_B  = 5'd9;
  localparam logic [4:0] ST_PW_C  = 5'd10;
  localparam logic [4:0] ST_TAIL  = 5'd11;
  localparam logic [4:0] ST_T4_A  = 5'd12;
  localparam logic [4:0] ST_T4_B  = 5'd13;
  localparam logic [4:0] ST_TB_A  = 5'd14;
  localparam logic [4:0] ST_TB_B  = 5'd15;
  localparam logic [4:0] ST_AV_A  = 5'd16;
  localparam logic [4:0] ST_AV_B  = 5'd17;
  localparam logic [4:0] ST_AV_C  = 5'd18;

  logic [4:0]  state;
  logic [63:0] seed;
  logic [63:0] lane [0:3];
  logic [63:0] pend [0:2];
  logic [1:0]  pcount;
  logic        stripe_seen;
  logic [63:0] total;
  logic [63:0] word_r;
  logic [3:0]  count_r;
  logic        last_r;
  logic [1:0]  idx;
  logic [2:0]  pos;
  logic [63:0] h;
  logic [63:0] t;
  logic [1:0]  mph;
  logic [63:0] pacc;

  logic [3:0]  in_count;
  logic        mul_state;
  logic [63:0] ma;
  logic [63:0] mb;
  logic [31:0] a32;
  logic [31:0] b32;
  logic [63:0] pp;
  logic [63:0] prod;
  logic        mul_done;
  logic [63:0] pend_sel;
  logic [63:0] tail_byte;
  logic [63:0] final_h;
  logic        out_load;

  assign s_tready = (state == ST_IDLE);
  assign in_count = (!s_tlast || s_tdata[67:64] > xxh_pkg::FULL_COUNT) ?
                    xxh_pkg::FULL_COUNT : s_tdata[67:64];
  assign out_load = (state == ST_AV_C) && (!m_tvalid || m_tready);

  always_comb begin
    unique case (idx)
      2'd0:    pend_sel = pend[0];
      2'd1:    pend_sel = pend[1];
      default: pend_sel = pend[2];
    endcase
  end

  assign tail_byte = {56'd0, word_r[pos*8 +: 8]};
  assign final_h   = h ^ (h >> 32);

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_state = 1'b1;
    ma = h;
    mb = xxh_pkg::PRIME1;
    unique case (state)
      ST_RND_A: begin
        ma = (idx == 2'd3) ? word_r : pend_sel;
        mb = xxh_pkg::PRIME2;
      end
      ST_RND_B: ma = lane[idx];
      ST_MRG_A: begin
        ma = lane[idx];
        mb = xxh_pkg::PRIME2;
      end
      ST_MRG_B: ma = t;
      ST_MRG_C: ma = h;
      ST_PW_A: begin
        ma = pend_sel;
        mb = xxh_pkg::PRIME2;
      end
      ST_PW_B: ma = t;
      ST_PW_C: ma = xxh_pkg::rotl64(h, 27);
      ST_T4_A: ma = {32'd0, word_r[31:0]};
      ST_T4_B: begin
        ma = xxh_pkg::rotl64(h, 23);
        mb = xxh_pkg::PRIME2;
      end
      ST_TB_A: begin
        ma = tail_byte;
        mb = xxh_pkg::PRIME5;
      end
      ST_TB_B: ma = xxh_pkg::rotl64(h, 11);
      ST_AV_A: begin
        ma = h ^ (h >> 33);
        mb = xxh_pkg::PRIME2;
      end
      ST_AV_B: begin
        ma = h ^ (h >> 29);
        mb = xxh_pkg::PRIME3;
      end
      default: mul_state = 1'b0;
    endcase
  end

  // Low 64 bits of ma*mb from three 32x32 partial products.
  always_comb begin
    unique case (mph)
      2'd0:    begin a32 = ma[31:0];  b32 = mb[31:0];  end
      2'd1:    begin a32 = ma[31:0];  b32 = mb[63:32]; end
      default: begin a32 = ma[63:32]; b32 = mb[31:0];  end
    endcase
  end
  assign pp       = a32 * b32;
  assign mul_done = mul_state && (mph == 2'd2);
  assign prod     = pacc + {pp[31:0], 32'd0};

  always_ff @(posedge clk) begin
    if (mul_state) begin
      if (mph == 2'd0) begin
        pacc <= pp;
      end else if (mph == 2'd1) begin
        pacc <= pacc + {pp[31:0], 32'd0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      seed        <= '0;
      pcount      <= '0;
      stripe_seen <= 1'b0;
      total       <= '0;
      mph         <= '0;
      m_tvalid    <= 1'b0;
      idx         <= '0;
      pos         <= '0;
    end else begin
      if (cfg_we) begin
        seed <= cfg_wdata;
      end
      if (out_load) begin
        m_tdata  <= final_h;
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (mul_state) begin
        mph <= (mph == 2'd2) ? 2'd0 : mph + 2'd1;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            word_r  <= s_tdata[63:0];
            count_r <= in_count;
            last_r  <= s_tlast;
            total   <= total + {60'd0, in_count};
            idx     <= '0;
            pos     <= '0;
            if (in_count == xxh_pkg::FULL_COUNT && pcount == 2'd3) begin
              state <= ST_RND_A;
              if (!stripe_seen) begin
                lane[0] <= seed + xxh_pkg::PRIME1 + xxh_pkg::PRIME2;
                lane[1] <= seed + xxh_pkg::PRIME2;
                lane[2] <= seed;
                lane[3] <= seed - xxh_pkg::PRIME1;
              end
            end else begin
              state <= ST_POST;
              if (in_count == xxh_pkg::FULL_COUNT) begin
                pend[pcount] <= s_tdata[63:0];
                pcount       <= pcount + 2'd1;
              end
            end
          end
        end
        ST_RND_A: if (mul_done) begin
          lane[idx] <= xxh_pkg::rotl64(lane[idx] + prod, 31);
          state     <= ST_RND_B;
        end
        ST_RND_B: if (mul_done) begin
          lane[idx] <= prod;
          if (idx == 2'd3) begin
            stripe_seen <= 1'b1;
            pcount      <= '0;
            state       <= ST_POST;
          end else begin
            idx   <= idx + 2'd1;
            state <= ST_RND_A;
          end
        end
        ST_POST: begin
          idx <= '0;
          if (!last_r) begin
            state <= ST_IDLE;
          end else if (stripe_seen) begin
            h <= xxh_pkg::rotl64(lane[0], 1) + xxh_pkg::rotl64(lane[1], 7) +
                 xxh_pkg::rotl64(lane[2], 12) + xxh_pkg::rotl64(lane[3], 18);
            state <= ST_MRG_A;
          end else begin
            h     <= seed + xxh_pkg::PRIME5;
            state <= ST_ADDL;
          end
        end
        ST_MRG_A: if (mul_done) begin
          t     <= xxh_pkg::rotl64(prod, 31);
          state <= ST_MRG_B;
        end
        ST_MRG_B: if (mul_done) begin
          h     <= h ^ prod;
          state <= ST_MRG_C;
        end
        ST_MRG_C: if (mul_done) begin
          h <= prod + xxh_pkg::PRIME4;
          if (idx == 2'd3) begin
            state <= ST_ADDL;
          end else begin
            idx   <= idx + 2'd1;
            state <= ST_MRG_A;
          end
        end
        ST_ADDL: begin
          h     <= h + total;
          idx   <= '0;
          state <= (pcount == 2'd0) ? ST_TAIL : ST_PW_A;
        end
        ST_PW_A: if (mul_done) begin
          t     <= xxh_pkg::rotl64(prod, 31);
          state <= ST_PW_B;
        end
        ST_PW_B: if (mul_done) begin
          h     <= h ^ prod;
          state <= ST_PW_C;
        end
        ST_PW_C: if (mul_done) begin
          h <= prod + xxh_pkg::PRIME4;
          if (idx + 2'd1 == pcount) begin
            state <= ST_TAIL;
          end else begin
            idx   <= idx + 2'd1;
            state <= ST_PW_A;
          end
        end
        ST_TAIL: begin
          // A full last word leaves no tail; otherwise one 4-byte piece if at least four bytes are valid, then bytes.
          if (count_r == xxh_pkg::FULL_COUNT) begin
            state <= ST_AV_A;
          end else if (count_r >= 4'd4 && pos == 3'd0) begin
            state <= ST_T4_A;
          end else if ({1'b0, pos} < count_r) begin
            state <= ST_TB_A;
          end else begin
            state <= ST_AV_A;
          end
        end
        ST_T4_A: if (mul_done) begin
          h     <= h ^ prod;
          state <= ST_T4_B;
        end
        ST_T4_B: if (mul_done) begin
          h     <= prod + xxh_pkg::PRIME3;
          pos   <= 3'd4;
          state <= ST_TAIL;
        end
        ST_TB_A: if (mul_done) begin
          h     <= h ^ prod;
          state <= ST_TB_B;
        end
        ST_TB_B: if (mul_done) begin
          h     <= prod;
          pos   <= pos + 3'd1;
          state <= ST_TAIL;
        end
        ST_AV_A: if (mul_done) begin
          h     <= prod;
          state <= ST_AV_B;
        end
        ST_AV_B: if (mul_done) begin
          h     <= prod;
          state <= ST_AV_C;
        end
        ST_AV_C: begin
          if (out_load) begin
            pcount      <= '0;
            stripe_seen <= 1'b0;
            total       <= '0;
            state       <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire
